// ===== design/assert_macros.svh =====
// Assertion macros for the checker module of the shaper.
// Each macro expands to one labeled concurrent assertion that reports through $error.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is high.
`define ACS_ASSERT_RST(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define ACS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== design/acs_pkg.sv =====
// Types, constants and the letter ROM of the Arabic contextual shaper.
// Used by acs_front, acs_queue, acs_back, the top level and the testbench; depends on nothing.
`default_nettype none

package acs_pkg;

  localparam int CP_W = 21;

  localparam logic [5:0]  IDX_NONE    = 6'd63;
  localparam int          ROM_ENTRIES = 52;
  localparam logic [15:0] BASE_CODE   = 16'h0622;
  localparam logic [7:0]  LAM_OFS     = 8'd34;

  localparam logic [CP_W-1:0] VOWEL_LO = 21'h00064B;
  localparam logic [CP_W-1:0] VOWEL_HI = 21'h000652;

  // Alef variants, as offsets from the base code, and their lam ligatures
  localparam logic [7:0] OFS_ALEF_MADDA       = 8'd0;
  localparam logic [7:0] OFS_ALEF_HAMZA_ABOVE = 8'd1;
  localparam logic [7:0] OFS_ALEF_HAMZA_BELOW = 8'd3;
  localparam logic [7:0] OFS_ALEF             = 8'd5;

  localparam logic [15:0] LIG_MADDA       = 16'hFEF5;
  localparam logic [15:0] LIG_HAMZA_ABOVE = 16'hFEF7;
  localparam logic [15:0] LIG_HAMZA_BELOW = 16'hFEF9;
  localparam logic [15:0] LIG_ALEF        = 16'hFEFB;

  // Joining class of a letter
  localparam logic [1:0] KIND_RIGHT   = 2'd0;  // joins backward only
  localparam logic [1:0] KIND_DUAL    = 2'd1;  // joins both ways
  localparam logic [1:0] KIND_NONE    = 2'd2;  // never joins
  localparam logic [1:0] KIND_TATWEEL = 2'd3;  // joins both ways, one code

  typedef struct packed {
    logic [7:0]  ofs;
    logic [15:0] fin;
    logic [1:0]  kind;
  } letter_t;

  // One classified queue entry
  typedef struct packed {
    logic [CP_W-1:0] cp;
    logic [5:0]      idx;
    logic            vowel;
    logic            last;
  } item_t;

  function automatic letter_t mk_letter(input logic [7:0] ofs, input logic [15:0] fin,
                                        input logic [1:0] kind);
    letter_t e;
    e.ofs  = ofs;
    e.fin  = fin;
    e.kind = kind;
    return e;
  endfunction

  function automatic letter_t letter_rom(input logic [5:0] idx);
    letter_t e;
    case (idx)
      6'd0:  e = mk_letter(8'd0,   16'hFE82, KIND_RIGHT);
      6'd1:  e = mk_letter(8'd1,   16'hFE84, KIND_RIGHT);
      6'd2:  e = mk_letter(8'd2,   16'hFE86, KIND_RIGHT);
      6'd3:  e = mk_letter(8'd3,   16'hFE88, KIND_RIGHT);
      6'd4:  e = mk_letter(8'd4,   16'hFE8A, KIND_DUAL);
      6'd5:  e = mk_letter(8'd5,   16'hFE8E, KIND_RIGHT);
      6'd6:  e = mk_letter(8'd6,   16'hFE90, KIND_DUAL);
      6'd7:  e = mk_letter(8'd92,  16'hFB57, KIND_DUAL);
      6'd8:  e = mk_letter(8'd8,   16'hFE96, KIND_DUAL);
      6'd9:  e = mk_letter(8'd9,   16'hFE9A, KIND_DUAL);
      6'd10: e = mk_letter(8'd10,  16'hFE9E, KIND_DUAL);
      6'd11: e = mk_letter(8'd100, 16'hFB7B, KIND_DUAL);
      6'd12: e = mk_letter(8'd11,  16'hFEA2, KIND_DUAL);
      6'd13: e = mk_letter(8'd12,  16'hFEA6, KIND_DUAL);
      6'd14: e = mk_letter(8'd13,  16'hFEAA, KIND_RIGHT);
      6'd15: e = mk_letter(8'd14,  16'hFEAC, KIND_RIGHT);
      6'd16: e = mk_letter(8'd15,  16'hFEAE, KIND_RIGHT);
      6'd17: e = mk_letter(8'd16,  16'hFEB0, KIND_RIGHT);
      6'd18: e = mk_letter(8'd118, 16'hFB8B, KIND_RIGHT);
      6'd19: e = mk_letter(8'd17,  16'hFEB2, KIND_DUAL);
      6'd20: e = mk_letter(8'd18,  16'hFEB6, KIND_DUAL);
      6'd21: e = mk_letter(8'd19,  16'hFEBA, KIND_DUAL);
      6'd22: e = mk_letter(8'd20,  16'hFEBE, KIND_DUAL);
      6'd23: e = mk_letter(8'd21,  16'hFEC2, KIND_DUAL);
      6'd24: e = mk_letter(8'd22,  16'hFEC6, KIND_DUAL);
      6'd25: e = mk_letter(8'd23,  16'hFECA, KIND_DUAL);
      6'd26: e = mk_letter(8'd24,  16'hFECE, KIND_DUAL);
      6'd27: e = mk_letter(8'd30,  16'h0640, KIND_TATWEEL);
      6'd28: e = mk_letter(8'd31,  16'hFED2, KIND_DUAL);
      6'd29: e = mk_letter(8'd32,  16'hFED6, KIND_DUAL);
      6'd30: e = mk_letter(8'd135, 16'hFB8F, KIND_DUAL);
      6'd31: e = mk_letter(8'd33,  16'hFEDA, KIND_DUAL);
      6'd32: e = mk_letter(8'd141, 16'hFB93, KIND_DUAL);
      6'd33: e = mk_letter(8'd34,  16'hFEDE, KIND_DUAL);
      6'd34: e = mk_letter(8'd35,  16'hFEE2, KIND_DUAL);
      6'd35: e = mk_letter(8'd36,  16'hFEE6, KIND_DUAL);
      6'd36: e = mk_letter(8'd38,  16'hFEEE, KIND_RIGHT);
      6'd37: e = mk_letter(8'd37,  16'hFEEA, KIND_DUAL);
      6'd38: e = mk_letter(8'd39,  16'hFEF0, KIND_RIGHT);
      6'd39: e = mk_letter(8'd40,  16'hFEF2, KIND_DUAL);
      6'd40: e = mk_letter(8'd170, 16'hFBFD, KIND_DUAL);
      6'd41: e = mk_letter(8'd7,   16'hFE94, KIND_RIGHT);
      6'd42: e = mk_letter(8'd206, 16'h06F0, KIND_NONE);
      6'd43: e = mk_letter(8'd207, 16'h06F1, KIND_NONE);
      6'd44: e = mk_letter(8'd208, 16'h06F2, KIND_NONE);
      6'd45: e = mk_letter(8'd209, 16'h06F3, KIND_NONE);
      6'd46: e = mk_letter(8'd210, 16'h06F4, KIND_NONE);
      6'd47: e = mk_letter(8'd211, 16'h06F5, KIND_NONE);
      6'd48: e = mk_letter(8'd212, 16'h06F6, KIND_NONE);
      6'd49: e = mk_letter(8'd213, 16'h06F7, KIND_NONE);
      6'd50: e = mk_letter(8'd214, 16'h06F8, KIND_NONE);
      6'd51: e = mk_letter(8'd215, 16'h06F9, KIND_NONE);
      default: e = mk_letter(8'd0, 16'h0000, KIND_NONE);
    endcase
    return e;
  endfunction

  function automatic logic joins_back(input logic [1:0] kind);
    return kind != KIND_NONE;
  endfunction

  function automatic logic joins_fwd(input logic [1:0] kind);
    return (kind == KIND_DUAL) || (kind == KIND_TATWEEL);
  endfunction

endpackage

`default_nettype wire

// ===== design/acs_front.sv =====
// Front end: accepts code points and classifies them against the letter ROM.
// Depends on acs_pkg (letter_rom, item_t).
`default_nettype none

module acs_front (
  input  wire logic                    in_valid,
  output logic                         in_ready,
  input  wire logic [acs_pkg::CP_W-1:0] code_point,
  input  wire logic                    last_flag,
  input  wire logic                    room,
  output logic                         push,
  output acs_pkg::item_t               push_item
);

  function automatic logic letter_hit(input logic [acs_pkg::CP_W-1:0] cp,
                                      input acs_pkg::letter_t e);
    logic [acs_pkg::CP_W-1:0] fin;
    logic [acs_pkg::CP_W-1:0] base;
    logic                     hit;
    fin  = {5'b0, e.fin};
    base = {5'b0, acs_pkg::BASE_CODE + {8'b0, e.ofs}};
    hit  = (cp == base) || (cp == fin);
    if (e.kind == acs_pkg::KIND_RIGHT || e.kind == acs_pkg::KIND_DUAL) begin
      hit = hit || (cp == fin - 21'd1);
    end
    if (e.kind == acs_pkg::KIND_DUAL) begin
      hit = hit || (cp == fin + 21'd1) || (cp == fin + 21'd2);
    end
    return hit;
  endfunction

  logic [5:0] idx;

  // First matching entry wins: scan from the top so the lowest index lands last
  always_comb begin
    idx = acs_pkg::IDX_NONE;
    for (int i = acs_pkg::ROM_ENTRIES - 1; i >= 0; i--) begin
      if (letter_hit(code_point, acs_pkg::letter_rom(6'(i)))) begin
        idx = 6'(i);
      end
    end
  end

  assign in_ready        = room;
  assign push            = in_valid && room;
  assign push_item.cp    = code_point;
  assign push_item.idx   = idx;
  assign push_item.vowel = (code_point >= acs_pkg::VOWEL_LO) &&
                           (code_point <= acs_pkg::VOWEL_HI);
  assign push_item.last  = last_flag;

endmodule

`default_nettype wire

// ===== design/acs_queue.sv =====
// Shift queue between front and back; exposes the head and two look-ahead slots.
// Depends on acs_pkg (item_t). Pops one or two entries per cycle as pop_n asks, or none while the back end stalls.
`default_nettype none

module acs_queue #(
  parameter int DEPTH = 4
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 push,
  input  wire acs_pkg::item_t       push_item,
  input  wire logic [1:0]           pop_n,
  output acs_pkg::item_t [2:0]      win,
  output logic [2:0]                win_valid,
  output logic                      room
);

  localparam int CNT_W = $clog2(DEPTH + 1);

  acs_pkg::item_t   slots [DEPTH];
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] cnt_pop;

  assign cnt_pop = count - CNT_W'(pop_n);
  assign room    = count != CNT_W'(DEPTH);

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= cnt_pop + CNT_W'(push);
    end
  end

  genvar g;
  for (g = 0; g < DEPTH; g++) begin : g_slot
    if (g + 2 < DEPTH) begin : g_two
      always_ff @(posedge clk) begin
        if (push && cnt_pop == CNT_W'(g)) begin
          slots[g] <= push_item;
        end else if (pop_n == 2'd1) begin
          slots[g] <= slots[g+1];
        end else if (pop_n == 2'd2) begin
          slots[g] <= slots[g+2];
        end
      end
    end else if (g + 1 < DEPTH) begin : g_one
      always_ff @(posedge clk) begin
        if (push && cnt_pop == CNT_W'(g)) begin
          slots[g] <= push_item;
        end else if (pop_n == 2'd1) begin
          slots[g] <= slots[g+1];
        end
      end
    end else begin : g_tail
      always_ff @(posedge clk) begin
        if (push && cnt_pop == CNT_W'(g)) begin
          slots[g] <= push_item;
        end
      end
    end
  end

  for (g = 0; g < 3; g++) begin : g_win
    assign win[g]       = slots[g];
    assign win_valid[g] = count > CNT_W'(g);
  end

endmodule

`default_nettype wire

// ===== design/acs_back.sv =====
// Back end: joining decision, lam-alef ligatures and the registered output stage.
// Depends on acs_pkg (letter_rom, item_t, joining helpers).
`default_nettype none

module acs_back (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire acs_pkg::item_t [2:0]     win,
  input  wire logic [2:0]               win_valid,
  output logic [1:0]                    pop_n,
  output logic                          out_valid,
  input  wire logic                     out_ready,
  output logic [acs_pkg::CP_W-1:0]      glyph_code,
  output logic                          out_last
);

  acs_pkg::item_t   head;
  acs_pkg::letter_t e;
  acs_pkg::letter_t nx_e;
  logic [5:0]       nx;
  logic             is_unknown;
  logic             ready;
  logic             fire;
  logic             cnx;
  logic             lig;
  logic [15:0]      lig_code;
  logic [15:0]      form;
  logic [acs_pkg::CP_W-1:0] code;
  logic             last_next;
  logic             prev_joins;
  logic             prev_joins_next;

  assign head       = win[0];
  assign e          = acs_pkg::letter_rom(head.idx);
  assign is_unknown = !head.vowel && head.idx == acs_pkg::IDX_NONE;

  // Find the next letter, past at most one vowel; the string end counts as a break
  always_comb begin
    nx    = acs_pkg::IDX_NONE;
    ready = win_valid[0];
    if (win_valid[0] && !head.vowel && !is_unknown && !head.last) begin
      if (!win_valid[1]) begin
        ready = 1'b0;
      end else if (win[1].vowel) begin
        if (!win[1].last) begin
          if (win_valid[2]) begin
            nx = win[2].idx;
          end else begin
            ready = 1'b0;
          end
        end
      end else begin
        nx = win[1].idx;
      end
    end
  end

  assign nx_e = acs_pkg::letter_rom(nx);
  assign cnx  = (nx != acs_pkg::IDX_NONE) && acs_pkg::joins_back(nx_e.kind);

  always_comb begin
    lig_code = 16'h0000;
    lig      = 1'b0;
    if (e.ofs == acs_pkg::LAM_OFS && nx != acs_pkg::IDX_NONE) begin
      lig = 1'b1;
      case (nx_e.ofs)
        acs_pkg::OFS_ALEF_MADDA:       lig_code = acs_pkg::LIG_MADDA;
        acs_pkg::OFS_ALEF_HAMZA_ABOVE: lig_code = acs_pkg::LIG_HAMZA_ABOVE;
        acs_pkg::OFS_ALEF_HAMZA_BELOW: lig_code = acs_pkg::LIG_HAMZA_BELOW;
        acs_pkg::OFS_ALEF:             lig_code = acs_pkg::LIG_ALEF;
        default:                       lig      = 1'b0;
      endcase
    end
  end

  always_comb begin
    if (prev_joins && cnx) begin
      form = (e.kind == acs_pkg::KIND_DUAL) ? e.fin + 16'd2 : e.fin;
    end else if (cnx) begin
      case (e.kind)
        acs_pkg::KIND_DUAL:  form = e.fin + 16'd1;
        acs_pkg::KIND_RIGHT: form = e.fin - 16'd1;
        default:             form = e.fin;
      endcase
    end else if (prev_joins) begin
      form = e.fin;
    end else begin
      form = (e.kind == acs_pkg::KIND_DUAL || e.kind == acs_pkg::KIND_RIGHT) ?
             e.fin - 16'd1 : e.fin;
    end
  end

  always_comb begin
    if (head.vowel || is_unknown) begin
      code = head.cp;
    end else if (lig) begin
      code = {5'b0, lig_code + {15'b0, prev_joins}};
    end else begin
      code = {5'b0, form};
    end
  end

  // A ligature swallows the following entry; its end mark moves onto the ligature
  assign last_next = (lig && !head.vowel && !is_unknown) ? win[1].last : head.last;
  assign fire      = ready && (!out_valid || out_ready);
  assign pop_n     = !fire ? 2'd0 : ((lig && !head.vowel && !is_unknown) ? 2'd2 : 2'd1);

  always_comb begin
    if (last_next || is_unknown || lig) begin
      prev_joins_next = 1'b0;
    end else if (head.vowel) begin
      prev_joins_next = prev_joins;
    end else begin
      prev_joins_next = acs_pkg::joins_fwd(e.kind);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      prev_joins <= 1'b0;
    end else if (fire) begin
      out_valid  <= 1'b1;
      prev_joins <= prev_joins_next;
    end else if (out_ready) begin
      out_valid  <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      glyph_code <= code;
      out_last   <= last_next;
    end
  end

endmodule

`default_nettype wire

// ===== design/arabic_contextual_shaper.sv =====
// Top level of the Arabic contextual shaper: classifier, queue and shaping back end.
// Depends on acs_pkg, acs_front, acs_queue and acs_back.
//
//   channel  dir  handshake                tdata                     tlast
//   s_axis   in   s_tvalid / s_tready      [20:0] code_point         last_of_string
//   m_axis   out  m_tvalid / m_tready      [20:0] glyph_code         last_of_string_res
//
// Sustained rate is one code point per cycle while the output does not stall; a lam-alef
// pair leaves the queue in one pop. A letter is shaped once its look-ahead (up to two
// following points) sits in the queue, and its result is registered in the output stage.
// Reset clears the queue count, the output valid and the joining history.
// Either side may stall: the queue absorbs output stalls until it is full.
`default_nettype none

module arabic_contextual_shaper #(
  parameter int QUEUE_DEPTH = 4
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [23:0] s_tdata,   // [20:0] code_point, [23:21] zero
  input  wire logic        s_tlast,
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [23:0]      m_tdata,   // [20:0] glyph_code, [23:21] zero
  output logic             m_tlast
);

  logic                      push;
  acs_pkg::item_t            push_item;
  logic                      room;
  acs_pkg::item_t [2:0]      win;
  logic [2:0]                win_valid;
  logic [1:0]                pop_n;
  logic [acs_pkg::CP_W-1:0]  glyph_code;

  acs_front u_front (
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .code_point (s_tdata[acs_pkg::CP_W-1:0]),
    .last_flag  (s_tlast),
    .room       (room),
    .push       (push),
    .push_item  (push_item)
  );

  acs_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .pop_n     (pop_n),
    .win       (win),
    .win_valid (win_valid),
    .room      (room)
  );

  acs_back u_back (
    .clk        (clk),
    .rst        (rst),
    .win        (win),
    .win_valid  (win_valid),
    .pop_n      (pop_n),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .glyph_code (glyph_code),
    .out_last   (m_tlast)
  );

  assign m_tdata = {3'b0, glyph_code};

endmodule

`default_nettype wire

// ===== design/acs_checker.sv =====
// Port-level checker for arabic_contextual_shaper, bound to the top level below.
// Depends on assert_macros.svh.
`default_nettype none

`include "assert_macros.svh"

module acs_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_tvalid,
  input wire logic        s_tready,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [23:0] m_tdata,
  input wire logic        m_tlast
);

  // hold a stalled result
  `ACS_ASSERT_RST(a_out_hold, clk, rst, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast), "stalled result changed")

  `ACS_ASSERT_RST(a_pad_zero, clk, rst, m_tvalid |-> m_tdata[23:21] == 3'b000, "output pad bits set")

  `ACS_ASSERT_ALWAYS(a_rst_no_out, clk, $past(rst) |-> !m_tvalid, "result right after reset")

  `ACS_ASSERT_ALWAYS(a_rst_ready, clk, $past(rst) |-> s_tready, "input not ready after reset")

endmodule

bind arabic_contextual_shaper acs_checker u_acs_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast)
);

`default_nettype wire

// ===== tb/tb_arabic_contextual_shaper.sv =====
// Self-checking testbench for arabic_contextual_shaper: streams strings of code points
// and compares every shaped glyph with a cycle-free prediction held in this file.
// Depends only on the RTL (acs_pkg and the top level); no files, no arguments.
`default_nettype none

module tb_arabic_contextual_shaper;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CP_W        = acs_pkg::CP_W;
  localparam int N_LETTERS   = 52;
  localparam int NO_LETTER   = 63;
  localparam int BASE_CODE   = 'h0622;
  localparam int LAM_OFFSET  = 34;
  localparam int LAM_CODE    = BASE_CODE + LAM_OFFSET;
  localparam int VOWEL_FIRST = 'h064B;
  localparam int VOWEL_LAST  = 'h0652;
  localparam int CP_MASK     = 'h1FFFFF;

  localparam int ALEF_MADDA       = 'h0622;
  localparam int ALEF_HAMZA_ABOVE = 'h0623;
  localparam int ALEF_HAMZA_BELOW = 'h0625;
  localparam int ALEF_PLAIN       = 'h0627;
  localparam int LIG_MADDA        = 'hFEF5;
  localparam int LIG_HAMZA_ABOVE  = 'hFEF7;
  localparam int LIG_HAMZA_BELOW  = 'hFEF9;
  localparam int LIG_PLAIN        = 'hFEFB;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int DRAIN_CYCLES = 20;

  typedef enum logic [1:0] {JOIN_RIGHT, JOIN_DUAL, JOIN_NEVER, JOIN_TATWEEL} join_class_e;
  typedef enum logic [1:0] {FORM_ISOLATED, FORM_INITIAL, FORM_MEDIAL, FORM_FINAL} form_e;

  typedef struct {
    logic [CP_W-1:0] glyph;
    bit              last;
  } glyph_t;

  // Letter table: base code offset and final-form code, in match priority order
  localparam int unsigned LETTER_OFS [N_LETTERS] = '{
    0, 1, 2, 3, 4, 5, 6, 92, 8, 9, 10, 100, 11, 12, 13, 14, 15, 16, 118, 17,
    18, 19, 20, 21, 22, 23, 24, 30, 31, 32, 135, 33, 141, 34, 35, 36, 38, 37, 39, 40,
    170, 7, 206, 207, 208, 209, 210, 211, 212, 213, 214, 215};
  localparam int unsigned LETTER_FIN [N_LETTERS] = '{
    'hFE82, 'hFE84, 'hFE86, 'hFE88, 'hFE8A, 'hFE8E, 'hFE90, 'hFB57, 'hFE96, 'hFE9A,
    'hFE9E, 'hFB7B, 'hFEA2, 'hFEA6, 'hFEAA, 'hFEAC, 'hFEAE, 'hFEB0, 'hFB8B, 'hFEB2,
    'hFEB6, 'hFEBA, 'hFEBE, 'hFEC2, 'hFEC6, 'hFECA, 'hFECE, 'h0640, 'hFED2, 'hFED6,
    'hFB8F, 'hFEDA, 'hFB93, 'hFEDE, 'hFEE2, 'hFEE6, 'hFEEE, 'hFEEA, 'hFEF0, 'hFEF2,
    'hFBFD, 'hFE94, 'h06F0, 'h06F1, 'h06F2, 'h06F3, 'h06F4, 'h06F5, 'h06F6, 'h06F7,
    'h06F8, 'h06F9};

  logic              clk;
  logic              rst;
  logic              s_tvalid;
  logic              s_tready;
  logic [23:0]       s_tdata;
  logic              s_tlast;
  logic              m_tvalid;
  logic              m_tready;
  logic [23:0]       m_tdata;
  logic              m_tlast;

  // Shaper state as the prediction sees it
  logic [CP_W-1:0]   held_points [2];
  int                held_count;
  int                prev_letter;
  bit                skip_next;

  glyph_t            expected_glyphs [$];
  int                send_idle_pct;
  int                recv_idle_pct;
  int                error_count;
  int                points_sent;
  int                strings_sent;
  int                glyphs_seen;
  int                cycle_count;

  arabic_contextual_shaper dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  initial clk = 1'b0;
  always #2 clk = ~clk;

  function automatic join_class_e letter_class(input int idx);
    if (idx >= 42) return JOIN_NEVER;
    case (idx)
      0, 1, 2, 3, 5, 14, 15, 16, 17, 18, 36, 38, 41: return JOIN_RIGHT;
      27: return JOIN_TATWEEL;
      default: return JOIN_DUAL;
    endcase
  endfunction

  function automatic int glyph_form(input int idx, input form_e f);
    int fin;
    fin = LETTER_FIN[idx];
    case (letter_class(idx))
      JOIN_RIGHT: begin
        return (f == FORM_MEDIAL || f == FORM_FINAL) ? fin : fin - 1;
      end
      JOIN_DUAL: begin
        case (f)
          FORM_INITIAL: return fin + 1;
          FORM_MEDIAL: return fin + 2;
          FORM_ISOLATED: return fin - 1;
          default: return fin;
        endcase
      end
      default: return fin;
    endcase
  endfunction

  function automatic bit is_vowel(input logic [CP_W-1:0] c);
    return int'(c) >= VOWEL_FIRST && int'(c) <= VOWEL_LAST;
  endfunction

  // First table entry hit by any of its codes wins
  function automatic int find_letter(input logic [CP_W-1:0] c);
    int i;
    int v;
    v = int'(c);
    for (i = 0; i < N_LETTERS; i++) begin
      if (v == BASE_CODE + int'(LETTER_OFS[i]) || v == glyph_form(i, FORM_FINAL) ||
          v == glyph_form(i, FORM_INITIAL) || v == glyph_form(i, FORM_MEDIAL) ||
          v == glyph_form(i, FORM_ISOLATED))
        return i;
    end
    return NO_LETTER;
  endfunction

  function automatic bit letter_joins_back(input int idx);
    return idx < N_LETTERS && letter_class(idx) != JOIN_NEVER;
  endfunction

  function automatic bit letter_joins_fwd(input int idx);
    return idx < N_LETTERS &&
           (letter_class(idx) == JOIN_DUAL || letter_class(idx) == JOIN_TATWEEL);
  endfunction

  function automatic int lam_ligature(input int alef_idx);
    int a;
    if (alef_idx >= N_LETTERS) return 0;
    a = BASE_CODE + int'(LETTER_OFS[alef_idx]);
    case (a)
      ALEF_MADDA: return LIG_MADDA;
      ALEF_HAMZA_ABOVE: return LIG_HAMZA_ABOVE;
      ALEF_HAMZA_BELOW: return LIG_HAMZA_BELOW;
      ALEF_PLAIN: return LIG_PLAIN;
      default: return 0;
    endcase
  endfunction

  function automatic void clear_shaping();
    held_points[0] = '0;
    held_points[1] = '0;
    held_count = 0;
    prev_letter = NO_LETTER;
    skip_next = 1'b0;
  endfunction

  // Shape every point whose look-ahead is now complete and queue the glyphs
  function automatic void shape_point(input logic [CP_W-1:0] cp, input bit last);
    logic [CP_W-1:0] win [3];
    glyph_t          batch [$];
    glyph_t          g;
    int              k;
    int              i;
    int              cur;
    int              nxt;
    int              code;
    bit              back;
    bit              stall;
    for (i = 0; i < held_count && i < 2; i++) win[i] = held_points[i];
    k = (held_count > 2) ? 2 : held_count;
    win[k] = cp;
    k++;
    stall = 1'b0;
    while (k > 0 && batch.size() < 3 && !stall) begin
      g.last = 1'b0;
      if (skip_next) begin
        skip_next = 1'b0;
      end else if (is_vowel(win[0])) begin
        g.glyph = win[0];
        batch.push_back(g);
      end else begin
        cur = find_letter(win[0]);
        if (cur == NO_LETTER) begin
          prev_letter = NO_LETTER;
          g.glyph = win[0];
          batch.push_back(g);
        end else begin
          nxt = NO_LETTER;
          if (k >= 2) begin
            if (is_vowel(win[1])) begin
              if (k >= 3) nxt = find_letter(win[2]);
              else if (!last) stall = 1'b1;
            end else begin
              nxt = find_letter(win[1]);
            end
          end else if (!last) begin
            stall = 1'b1;
          end
          if (!stall) begin
            back = letter_joins_fwd(prev_letter);
            code = (int'(LETTER_OFS[cur]) == LAM_OFFSET) ? lam_ligature(nxt) : 0;
            if (code != 0) begin
              if (back) code++;
              prev_letter = NO_LETTER;
              skip_next = 1'b1;
            end else begin
              if (back && letter_joins_back(nxt)) code = glyph_form(cur, FORM_MEDIAL);
              else if (letter_joins_back(nxt)) code = glyph_form(cur, FORM_INITIAL);
              else if (back) code = glyph_form(cur, FORM_FINAL);
              else code = glyph_form(cur, FORM_ISOLATED);
              prev_letter = cur;
            end
            g.glyph = CP_W'(code & CP_MASK);
            batch.push_back(g);
          end
        end
      end
      if (!stall) begin
        for (i = 1; i < k; i++) win[i-1] = win[i];
        k--;
      end
    end
    if (last) begin
      if (batch.size() > 0) batch[batch.size()-1].last = 1'b1;
      clear_shaping();
    end else begin
      if (k > 2) k = 2;
      for (i = 0; i < 2; i++) held_points[i] = (i < k) ? win[i] : '0;
      held_count = k;
    end
    foreach (batch[j]) expected_glyphs.push_back(batch[j]);
  endfunction

  task automatic report_mismatch(input string what);
    error_count++;
    $display("[%0t] mismatch: %s", $realtime, what);
  endtask

  task automatic send_point(input logic [CP_W-1:0] cp, input bit last);
    while (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {3'b000, cp};
    s_tlast  <= last;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    shape_point(cp, last);
    points_sent++;
  endtask

  task automatic send_string(input logic [CP_W-1:0] pts [$]);
    foreach (pts[i]) send_point(pts[i], i == pts.size() - 1);
    strings_sent++;
  endtask

  function automatic logic [CP_W-1:0] pick_point();
    int r;
    int idx;
    r = $urandom_range(0, 99);
    idx = $urandom_range(0, N_LETTERS - 1);
    if (r < 55) return CP_W'(BASE_CODE + int'(LETTER_OFS[idx]));
    if (r < 65) return CP_W'(glyph_form(idx, form_e'($urandom_range(0, 3))));
    if (r < 80) return CP_W'($urandom_range(VOWEL_FIRST, VOWEL_LAST));
    if (r < 88) return CP_W'($urandom_range('h0600, 'h06FF));
    return CP_W'($urandom & CP_MASK);
  endfunction

  function automatic logic [CP_W-1:0] pick_alef();
    case ($urandom_range(0, 3))
      0: return CP_W'(ALEF_MADDA);
      1: return CP_W'(ALEF_HAMZA_ABOVE);
      2: return CP_W'(ALEF_HAMZA_BELOW);
      default: return CP_W'(ALEF_PLAIN);
    endcase
  endfunction

  // All four alef variants, joined and unjoined lam, a vowel between lam and alef
  task automatic test_lam_alef();
    send_string('{21'h000644, 21'h000622});
    send_string('{21'h000628, 21'h000644, 21'h000623});
    send_string('{21'h000644, 21'h00064E, 21'h000625});
    send_string('{21'h000644, 21'h000627});
  endtask

  // Initial, medial and final forms, tatweel, vowels skipped in look-ahead,
  // presentation-form codes taken as input
  task automatic test_joining_forms();
    send_string('{21'h000628, 21'h000640, 21'h00064B, 21'h000628});
    send_string('{21'h000645, 21'h000645, 21'h000645});
    send_string('{21'h00FE91, 21'h00FEEE, 21'h000652});
  endtask

  // Unknown and out-of-range points, digits, a code that aliases lam in 16 bits,
  // and a one-point string at the low extreme
  task automatic test_pass_through();
    send_string('{21'h1FFFFF, 21'h0006F0, 21'h010644});
    send_string('{21'h000000});
  endtask

  // Mostly letter runs with random content, lam-alef pairs mixed in, plus noise
  task automatic test_random_strings(input int n_points);
    logic [CP_W-1:0] pts [$];
    int              len;
    int              goal;
    goal = points_sent + n_points;
    while (points_sent < goal) begin
      pts.delete();
      len = $urandom_range(1, 7);
      while (pts.size() < len) begin
        if ($urandom_range(0, 99) < 15) begin
          pts.push_back(CP_W'(LAM_CODE));
          if ($urandom_range(0, 99) < 30)
            pts.push_back(CP_W'($urandom_range(VOWEL_FIRST, VOWEL_LAST)));
          pts.push_back(pick_alef());
        end else begin
          pts.push_back(pick_point());
        end
      end
      send_string(pts);
    end
  endtask

  // Output side: random backpressure
  always @(posedge clk) begin
    if (recv_idle_pct == 0) m_tready <= 1'b1;
    else m_tready <= $urandom_range(0, 99) >= recv_idle_pct;
  end

  // Compare each glyph transaction with the oldest prediction
  always @(posedge clk) begin
    glyph_t want;
    if (!rst && m_tvalid && m_tready) begin
      glyphs_seen++;
      if (expected_glyphs.size() == 0) begin
        report_mismatch($sformatf("unexpected glyph %h last %b", m_tdata, m_tlast));
      end else begin
        want = expected_glyphs.pop_front();
        if (m_tdata !== {3'b000, want.glyph})
          report_mismatch($sformatf("glyph %h, want %h", m_tdata, want.glyph));
        if (m_tlast !== want.last)
          report_mismatch($sformatf("tlast %b on glyph %h, want %b", m_tlast, m_tdata,
                                    want.last));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_arabic_contextual_shaper: done, errors");
      $finish;
    end
  end

  initial begin
    rst      <= 1'b1;
    s_tvalid <= 1'b0;
    s_tdata  <= '0;
    s_tlast  <= 1'b0;
    m_tready <= 1'b0;
    send_idle_pct = 27;
    recv_idle_pct = 48;
    error_count  = 0;
    points_sent  = 0;
    strings_sent = 0;
    glyphs_seen  = 0;
    cycle_count  = 0;
    clear_shaping();
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_lam_alef();
    test_joining_forms();
    test_pass_through();
    test_random_strings(66);
    send_idle_pct = 48;
    recv_idle_pct = 27;
    test_random_strings(66);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_strings(66);

    s_tvalid <= 1'b0;
    while (expected_glyphs.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Shaped %0d strings of %0d code points into %0d glyphs,", strings_sent,
             points_sent, glyphs_seen);
    $display("under input gaps, output stalls and full rate; %0d mismatches.", error_count);
    if (error_count == 0) begin
      $display("tb_arabic_contextual_shaper: done, clean");
    end else begin
      $display("tb_arabic_contextual_shaper: done, errors");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== files.f =====
+incdir+design
design/acs_pkg.sv
design/acs_front.sv
design/acs_queue.sv
design/acs_back.sv
design/arabic_contextual_shaper.sv
design/acs_checker.sv
tb/tb_arabic_contextual_shaper.sv
